@@ sv/rcci_pkg.sv @@
// shared types, constants and register indexes for the capped cylinder intersect core
package rcci_pkg;

  // default number of fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 2'd2;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // register reset values
  localparam logic [30:0] RADIUS_RST = 31'd32768;
  localparam logic [30:0] HEIGHT_RST = 31'd65536;
  localparam logic [1:0]  AXIS_RST   = AXIS_Y;

  // square root and root distance limits
  localparam int ROOT_W = 64;
  localparam logic [63:0] T_CAP = 64'h4000_0000_0000_0000;

  // point on the ray unit latency
  localparam int ALONG_LAT = 3;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SIDE   = 2'd1,
    KIND_TOP    = 2'd2,
    KIND_BOTTOM = 2'd3
  } hit_kind_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]        nt;
  } ray_t;

  // item data riding beside the square root
  typedef struct packed {
    ray_t               ray;
    logic [63:0]        a;
    logic signed [64:0] h;
    logic               miss;
  } sq_side_t;

  // item data riding beside the dividers
  typedef struct packed {
    ray_t ray;
    logic miss;
    logic sm;
    logic sp;
    logic st;
    logic sb;
    logic dnz;
  } dv_side_t;

  // item data riding beside the height point units
  typedef struct packed {
    ray_t               ray;
    logic               miss;
    logic               dnz;
    logic signed [63:0] tm;
    logic signed [63:0] tp;
    logic signed [63:0] tt;
    logic signed [63:0] tb;
  } al_side_t;

  // item data riding beside the hit point units
  typedef struct packed {
    logic        hit;
    hit_kind_t   kind;
    logic [30:0] t;
  } fin_side_t;

endpackage

@@ sv/rcci_delay.sv @@
// delay line with enable that carries an item's valid bit and side data
module rcci_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     data_r [DEPTH];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];

endmodule

@@ sv/rcci_sqrt_pipe.sv @@
// pipelined integer square root, one root bit per stage
module rcci_sqrt_pipe
  import rcci_pkg::*;
#(
  parameter int RW = ROOT_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] x_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    logic [2*RW-1:0] x_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RW:0], x_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_in << 2;
        rem_r[k]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

@@ sv/rcci_div_pipe.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
module rcci_div_pipe #(
  parameter int NUM_W = 83,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int AW = DEN_W + 1 + NUM_W;

  logic [AW-1:0]    acc_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  genvar k;
  for (k = 0; k < NUM_W; k++) begin : g_stage
    logic [AW-1:0]    acc_in;
    logic [DEN_W-1:0] den_in;
    logic [AW-1:0]    sh;
    logic [DEN_W:0]   hi;
    logic [DEN_W:0]   hi_sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign acc_in = {{(DEN_W+1){1'b0}}, num};
      assign den_in = den;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign den_in = den_r[k-1];
    end

    // shift in the next numerator bit and subtract when it fits
    assign sh     = acc_in << 1;
    assign hi     = sh[AW-1 -: DEN_W+1];
    assign ge     = (hi >= {1'b0, den_in});
    assign hi_sub = hi - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= {(ge ? hi_sub : hi), sh[NUM_W-1:1], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = acc_r[NUM_W-1][NUM_W-1:0];

endmodule

@@ sv/rcci_along.sv @@
// point on the ray along one axis: o + floor(t*d / 2^frac), saturated to 32 bits
module rcci_along #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] o,
  input  logic signed [31:0] d,
  input  logic signed [63:0] t,
  output logic signed [31:0] p
);

  logic signed [64:0] pl;
  logic signed [63:0] ph;
  logic signed [64:0] pl_r;
  logic signed [63:0] ph_r;
  logic signed [31:0] o1_r;
  logic signed [31:0] o2_r;
  logic signed [95:0] prod;
  logic signed [95:0] prod_r;
  logic signed [95:0] shv;
  logic signed [96:0] sum;
  logic signed [31:0] p_nxt;
  logic signed [31:0] p_r;

  // split 64 by 32 product into two 32 by 32 halves
  assign pl = $signed({1'b0, t[31:0]}) * d;
  assign ph = $signed(t[63:32]) * d;

  // recombine halves
  assign prod = $signed({ph_r, 32'd0}) + $signed({{31{pl_r[64]}}, pl_r});

  // floor shift, add origin, saturate
  assign shv = prod_r >>> FRAC_BITS;
  assign sum = $signed({shv[95], shv}) + $signed({{65{o2_r[31]}}, o2_r});

  always_comb begin
    if (sum[96:31] == {66{sum[96]}}) begin
      p_nxt = sum[31:0];
    end else if (sum[96]) begin
      p_nxt = 32'sh8000_0000;
    end else begin
      p_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= pl;
      ph_r   <= ph;
      o1_r   <= o;
      prod_r <= prod;
      o2_r   <= o1_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

@@ sv/ray_capped_cylinder_intersect_core.sv @@
// top level of the ray against capped cylinder intersection pipeline
//
// Use: one ray enters on the in_ channel (valid/ready) with the current nearest
// distance; exactly one result leaves on the out_ channel (valid/ready) for
// each ray, in order. out_hit is 1 when the ray meets the cylinder side or a
// cap at a distance below in_nearest_t; on a miss every result field is zero.
// Cylinder radius, height and axis come from the cfg_ write port and must be
// written only while no ray is in flight.
// Path from input accept to out_valid: six front stages, the 64 stage square
// root, two stages, the 67 + FRAC_BITS stage dividers, the signed distance
// register, then two point-on-ray units of three stages each with a classify
// stage between and the output register.
// Throughput: one ray per cycle unless stalled; every stage advances together.
// Reset: synchronous active low rst_n clears all valid bits and loads the
// register reset values (radius 0.5, height 1.0, y axis).
// Stall: while a result waits in the output register and another is ready
// behind it the whole pipeline holds and in_ready drops; bubbles let input go on.
module ray_capped_cylinder_intersect_core
  import rcci_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [30:0]          cfg_wdata,
  // ray input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_origin_x,
  input  logic signed [31:0]   in_origin_y,
  input  logic signed [31:0]   in_origin_z,
  input  logic signed [31:0]   in_dir_x,
  input  logic signed [31:0]   in_dir_y,
  input  logic signed [31:0]   in_dir_z,
  input  logic [30:0]          in_nearest_t,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [30:0]          out_hit_t,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [31:0]   out_norm_x,
  output logic signed [31:0]   out_norm_y,
  output logic signed [31:0]   out_norm_z
);

  localparam int NW        = 67 + FRAC_BITS;
  localparam int CAP_NUM_W = 34;
  localparam int CAP_DEN_W = 33;
  localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] axis_comp(input logic [1:0] axis,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
    logic signed [31:0] r;
    case (axis)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      default: r = z;
    endcase
    return r;
  endfunction

  // configuration registers
  logic [30:0] cfg_radius_r;
  logic [30:0] cfg_height_r;
  logic [1:0]  cfg_axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= RADIUS_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_axis_r   <= AXIS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: cfg_radius_r <= cfg_wdata;
        CFG_HEIGHT: cfg_height_r <= cfg_wdata;
        CFG_AXIS:   cfg_axis_r   <= cfg_wdata[1:0];
        default:    ;
      endcase
    end
  end

  logic adv;
  logic vlast;
  logic out_valid_r;

  // the pipeline moves unless a finished item is blocked behind a full output
  assign adv      = !vlast || !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: select tube plane components, products
  logic signed [31:0] u_o, v_o, u_d, v_d;
  ray_t               ray_in;

  always_comb begin
    case (cfg_axis_r)
      AXIS_X: begin
        u_o = in_origin_y; v_o = in_origin_z; u_d = in_dir_y; v_d = in_dir_z;
      end
      AXIS_Y: begin
        u_o = in_origin_z; v_o = in_origin_x; u_d = in_dir_z; v_d = in_dir_x;
      end
      default: begin
        u_o = in_origin_x; v_o = in_origin_y; u_d = in_dir_x; v_d = in_dir_y;
      end
    endcase
  end

  assign ray_in = '{ox: in_origin_x, oy: in_origin_y, oz: in_origin_z,
                    dx: in_dir_x, dy: in_dir_y, dz: in_dir_z, nt: in_nearest_t};

  logic               v1_r;
  ray_t               ray1_r;
  logic signed [63:0] pdu2_r, pdv2_r, phu_r, phv_r, pou2_r, pov2_r;
  logic [61:0]        r2_r;

  // ---------------- stage 2: a, h, c
  logic               v2_r;
  ray_t               ray2_r;
  logic [63:0]        a2_r;
  logic signed [64:0] h2_r, c2_r;

  // ---------------- stage 3: magnitudes
  logic               v3_r;
  ray_t               ray3_r;
  logic [63:0]        a3_r, hm3_r, cm3_r;
  logic signed [64:0] h3_r, hneg3, cneg3;
  logic               cn3_r, az3_r;

  assign hneg3 = -h2_r;
  assign cneg3 = -c2_r;

  // ---------------- stage 4: partial products of h^2 and a*|c|
  logic               v4_r;
  ray_t               ray4_r;
  logic [63:0]        a4_r;
  logic signed [64:0] h4_r;
  logic               cn4_r, az4_r;
  logic [63:0]        hll_r, hlh_r, hhh_r, all_r, alh_r, ahl_r, ahh_r;

  // ---------------- stage 5: recombine
  logic               v5_r;
  ray_t               ray5_r;
  logic [63:0]        a5_r;
  logic signed [64:0] h5_r;
  logic               cn5_r, az5_r;
  logic [127:0]       hm2_5_r, ac5_r;

  // ---------------- stage 6: discriminant
  logic               v6_r;
  logic [128:0]       disc;
  logic [127:0]       disc6_r;
  sq_side_t           sq6_r;

  assign disc = cn5_r ? ({1'b0, hm2_5_r} + {1'b0, ac5_r})
                      : ({1'b0, hm2_5_r} - {1'b0, ac5_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      ray1_r <= ray_in;
      pdu2_r <= u_d * u_d;
      pdv2_r <= v_d * v_d;
      phu_r  <= u_d * u_o;
      phv_r  <= v_d * v_o;
      pou2_r <= u_o * u_o;
      pov2_r <= v_o * v_o;
      r2_r   <= cfg_radius_r * cfg_radius_r;
      // stage 2
      ray2_r <= ray1_r;
      a2_r   <= pdu2_r + pdv2_r;
      h2_r   <= $signed({phu_r[63], phu_r}) + $signed({phv_r[63], phv_r});
      c2_r   <= $signed({1'b0, pou2_r} + {1'b0, pov2_r} - {3'b0, r2_r});
      // stage 3
      ray3_r <= ray2_r;
      a3_r   <= a2_r;
      h3_r   <= h2_r;
      hm3_r  <= h2_r[64] ? hneg3[63:0] : h2_r[63:0];
      cm3_r  <= c2_r[64] ? cneg3[63:0] : c2_r[63:0];
      cn3_r  <= c2_r[64];
      az3_r  <= (a2_r == '0);
      // stage 4
      ray4_r <= ray3_r;
      a4_r   <= a3_r;
      h4_r   <= h3_r;
      cn4_r  <= cn3_r;
      az4_r  <= az3_r;
      hll_r  <= hm3_r[31:0] * hm3_r[31:0];
      hlh_r  <= hm3_r[31:0] * hm3_r[63:32];
      hhh_r  <= hm3_r[63:32] * hm3_r[63:32];
      all_r  <= a3_r[31:0] * cm3_r[31:0];
      alh_r  <= a3_r[31:0] * cm3_r[63:32];
      ahl_r  <= a3_r[63:32] * cm3_r[31:0];
      ahh_r  <= a3_r[63:32] * cm3_r[63:32];
      // stage 5
      ray5_r  <= ray4_r;
      a5_r    <= a4_r;
      h5_r    <= h4_r;
      cn5_r   <= cn4_r;
      az5_r   <= az4_r;
      hm2_5_r <= {hhh_r, 64'd0} + {31'd0, hlh_r, 33'd0} + {64'd0, hll_r};
      ac5_r   <= {ahh_r, 64'd0} + {32'd0, alh_r, 32'd0} + {32'd0, ahl_r, 32'd0}
                 + {64'd0, all_r};
      // stage 6
      disc6_r <= disc[127:0];
      sq6_r   <= '{ray: ray5_r, a: a5_r, h: h5_r, miss: az5_r | disc[128]};
    end
  end

  // ---------------- square root
  logic [63:0] s_root;
  logic        vs;
  sq_side_t    sqo;

  rcci_sqrt_pipe #(.RW(ROOT_W)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (disc6_r),
    .root (s_root)
  );

  rcci_delay #(.W($bits(sq_side_t)), .DEPTH(ROOT_W)) u_sq_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v6_r),
    .in_data   (sq6_r),
    .out_valid (vs),
    .out_data  (sqo)
  );

  // ---------------- stage 7: root numerators and cap numerators
  logic signed [66:0] hx;
  logic signed [31:0] oa7, da7;
  logic               v7_r;
  ray_t               ray7_r;
  logic [63:0]        a7_r;
  logic               miss7_r, dnz7_r;
  logic signed [66:0] nm7_r, np7_r;
  logic signed [33:0] numt7_r, numb7_r;
  logic signed [32:0] den7_r;

  assign hx  = $signed({{2{sqo.h[64]}}, sqo.h});
  assign oa7 = axis_comp(cfg_axis_r, sqo.ray.ox, sqo.ray.oy, sqo.ray.oz);
  assign da7 = axis_comp(cfg_axis_r, sqo.ray.dx, sqo.ray.dy, sqo.ray.dz);

  // ---------------- stage 8: magnitudes and signs for the dividers
  logic [66:0]        nm_mag, np_mag;
  logic signed [66:0] nm_neg, np_neg;
  logic signed [33:0] nt_neg, nb_neg;
  logic signed [32:0] den_neg;
  logic [33:0]        t_mag, b_mag;
  logic [32:0]        den_mag;
  logic               v8_r;
  logic [NW-1:0]      nm8_r, np8_r, nt8_r, nb8_r;
  logic [63:0]        a8_r;
  logic [32:0]        den8_r;
  dv_side_t           dv8_r;

  assign nm_neg  = -nm7_r;
  assign np_neg  = -np7_r;
  assign nt_neg  = -numt7_r;
  assign nb_neg  = -numb7_r;
  assign den_neg = -den7_r;
  assign nm_mag  = nm7_r[66] ? nm_neg : nm7_r;
  assign np_mag  = np7_r[66] ? np_neg : np7_r;
  assign t_mag   = numt7_r[33] ? nt_neg : numt7_r;
  assign b_mag   = numb7_r[33] ? nb_neg : numb7_r;
  assign den_mag = den7_r[32] ? den_neg : den7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (adv) begin
      v7_r <= vs;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 7
      ray7_r  <= sqo.ray;
      a7_r    <= sqo.a;
      miss7_r <= sqo.miss;
      nm7_r   <= -hx - $signed({3'b0, s_root});
      np7_r   <= -hx + $signed({3'b0, s_root});
      numt7_r <= $signed({3'b0, cfg_height_r}) - $signed({oa7[31], oa7, 1'b0});
      numb7_r <= -$signed({3'b0, cfg_height_r}) - $signed({oa7[31], oa7, 1'b0});
      den7_r  <= $signed({da7, 1'b0});
      dnz7_r  <= (da7 != '0);
      // stage 8
      nm8_r  <= {nm_mag, {FRAC_BITS{1'b0}}};
      np8_r  <= {np_mag, {FRAC_BITS{1'b0}}};
      nt8_r  <= {{(NW-CAP_NUM_W-FRAC_BITS){1'b0}}, t_mag, {FRAC_BITS{1'b0}}};
      nb8_r  <= {{(NW-CAP_NUM_W-FRAC_BITS){1'b0}}, b_mag, {FRAC_BITS{1'b0}}};
      a8_r   <= a7_r;
      den8_r <= den_mag;
      dv8_r  <= '{ray: ray7_r, miss: miss7_r, sm: nm7_r[66], sp: np7_r[66],
                  st: numt7_r[33] ^ den7_r[32], sb: numb7_r[33] ^ den7_r[32],
                  dnz: dnz7_r};
    end
  end

  // ---------------- dividers: two roots, two caps
  logic [NW-1:0] qm, qp, qt, qb;
  logic          vd;
  dv_side_t      dvo;

  rcci_div_pipe #(.NUM_W(NW), .DEN_W(64)) u_div_near (
    .clk (clk), .en (adv), .num (nm8_r), .den (a8_r), .quo (qm)
  );

  rcci_div_pipe #(.NUM_W(NW), .DEN_W(64)) u_div_far (
    .clk (clk), .en (adv), .num (np8_r), .den (a8_r), .quo (qp)
  );

  rcci_div_pipe #(.NUM_W(NW), .DEN_W(CAP_DEN_W)) u_div_top (
    .clk (clk), .en (adv), .num (nt8_r), .den (den8_r), .quo (qt)
  );

  rcci_div_pipe #(.NUM_W(NW), .DEN_W(CAP_DEN_W)) u_div_bot (
    .clk (clk), .en (adv), .num (nb8_r), .den (den8_r), .quo (qb)
  );

  rcci_delay #(.W($bits(dv_side_t)), .DEPTH(NW)) u_dv_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v8_r),
    .in_data   (dv8_r),
    .out_valid (vd),
    .out_data  (dvo)
  );

  // ---------------- stage 9: signed, capped distances
  logic [63:0] qm_cap, qp_cap;
  logic        v9_r;
  al_side_t    al9_r;

  assign qm_cap = (qm > NW'(T_CAP)) ? T_CAP : qm[63:0];
  assign qp_cap = (qp > NW'(T_CAP)) ? T_CAP : qp[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al9_r <= '{ray: dvo.ray, miss: dvo.miss, dnz: dvo.dnz,
                 tm: dvo.sm ? -$signed(qm_cap) : $signed(qm_cap),
                 tp: dvo.sp ? -$signed(qp_cap) : $signed(qp_cap),
                 tt: dvo.st ? -$signed(qt[63:0]) : $signed(qt[63:0]),
                 tb: dvo.sb ? -$signed(qb[63:0]) : $signed(qb[63:0])};
    end
  end

  // ---------------- height of the near and far side points
  logic signed [31:0] oa9, da9, an, af;
  logic               va;
  al_side_t           alo;

  assign oa9 = axis_comp(cfg_axis_r, al9_r.ray.ox, al9_r.ray.oy, al9_r.ray.oz);
  assign da9 = axis_comp(cfg_axis_r, al9_r.ray.dx, al9_r.ray.dy, al9_r.ray.dz);

  rcci_along #(.FRAC_BITS(FRAC_BITS)) u_along_near (
    .clk (clk), .en (adv), .o (oa9), .d (da9), .t (al9_r.tm), .p (an)
  );

  rcci_along #(.FRAC_BITS(FRAC_BITS)) u_along_far (
    .clk (clk), .en (adv), .o (oa9), .d (da9), .t (al9_r.tp), .p (af)
  );

  rcci_delay #(.W($bits(al_side_t)), .DEPTH(ALONG_LAT)) u_al_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v9_r),
    .in_data   (al9_r),
    .out_valid (va),
    .out_data  (alo)
  );

  // ---------------- stage 10: classify side, top cap, bottom cap
  logic signed [33:0] an2, af2, hgt, hgt_neg;
  logic               an_above, an_below, af_above, af_below;
  logic               tm_pos, tp_pos, tm_neg;
  hit_kind_t          kind_nxt;
  logic signed [63:0] t_nxt;
  logic               hit_nxt;
  logic               v10_r;
  ray_t               ray10_r;
  hit_kind_t          kind10_r;
  logic signed [63:0] t10_r;
  logic               hit10_r;

  assign an2      = $signed({an[31], an, 1'b0});
  assign af2      = $signed({af[31], af, 1'b0});
  assign hgt      = $signed({3'b0, cfg_height_r});
  assign hgt_neg  = -hgt;
  assign an_above = (an2 > hgt);
  assign an_below = (an2 < hgt_neg);
  assign af_above = (af2 > hgt);
  assign af_below = (af2 < hgt_neg);
  assign tm_pos   = !alo.tm[63] && (alo.tm != '0);
  assign tp_pos   = !alo.tp[63] && (alo.tp != '0);
  assign tm_neg   = alo.tm[63];

  always_comb begin
    kind_nxt = KIND_NONE;
    t_nxt    = '0;
    if (tm_pos && tp_pos) begin
      if (!an_above && !an_below) begin
        kind_nxt = KIND_SIDE;
        t_nxt    = alo.tm;
      end else if (alo.dnz && an_above && !af_above) begin
        kind_nxt = KIND_TOP;
        t_nxt    = alo.tt;
      end else if (alo.dnz && an_below && !af_below) begin
        kind_nxt = KIND_BOTTOM;
        t_nxt    = alo.tb;
      end
    end else if (tm_neg && tp_pos) begin
      // origin inside the tube: far side only
      if (!af_above && !af_below) begin
        kind_nxt = KIND_SIDE;
        t_nxt    = alo.tp;
      end
    end
    hit_nxt = !alo.miss && (kind_nxt != KIND_NONE) && !t_nxt[63]
              && (t_nxt < $signed({33'd0, alo.ray.nt}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (adv) begin
      v10_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray10_r  <= alo.ray;
      kind10_r <= kind_nxt;
      t10_r    <= t_nxt;
      hit10_r  <= hit_nxt;
    end
  end

  // ---------------- hit point on all three axes
  logic signed [31:0] px, py, pz;
  fin_side_t          fin10, fino;

  assign fin10 = '{hit: hit10_r, kind: kind10_r, t: t10_r[30:0]};

  rcci_along #(.FRAC_BITS(FRAC_BITS)) u_along_x (
    .clk (clk), .en (adv), .o (ray10_r.ox), .d (ray10_r.dx), .t (t10_r), .p (px)
  );

  rcci_along #(.FRAC_BITS(FRAC_BITS)) u_along_y (
    .clk (clk), .en (adv), .o (ray10_r.oy), .d (ray10_r.dy), .t (t10_r), .p (py)
  );

  rcci_along #(.FRAC_BITS(FRAC_BITS)) u_along_z (
    .clk (clk), .en (adv), .o (ray10_r.oz), .d (ray10_r.dz), .t (t10_r), .p (pz)
  );

  rcci_delay #(.W($bits(fin_side_t)), .DEPTH(ALONG_LAT)) u_fin_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v10_r),
    .in_data   (fin10),
    .out_valid (vlast),
    .out_data  (fino)
  );

  // ---------------- normal and miss zeroing
  logic               ax_x, ax_y, ax_z;
  logic signed [31:0] cap_n;
  logic signed [31:0] nx_nxt, ny_nxt, nz_nxt;

  assign ax_x  = (cfg_axis_r == AXIS_X);
  assign ax_y  = (cfg_axis_r == AXIS_Y);
  assign ax_z  = !ax_x && !ax_y;
  assign cap_n = (fino.kind == KIND_TOP) ? ONE_FIX : -ONE_FIX;

  always_comb begin
    case (fino.kind)
      KIND_SIDE: begin
        nx_nxt = ax_x ? '0 : px;
        ny_nxt = ax_y ? '0 : py;
        nz_nxt = ax_z ? '0 : pz;
      end
      KIND_TOP, KIND_BOTTOM: begin
        nx_nxt = ax_x ? cap_n : '0;
        ny_nxt = ax_y ? cap_n : '0;
        nz_nxt = ax_z ? cap_n : '0;
      end
      default: begin
        nx_nxt = '0;
        ny_nxt = '0;
        nz_nxt = '0;
      end
    endcase
  end

  // ---------------- output register
  logic               out_valid_nxt;
  logic               out_hit_r;
  logic [30:0]        out_hit_t_r;
  logic signed [31:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [31:0] out_norm_x_r, out_norm_y_r, out_norm_z_r;

  assign out_valid_nxt = (adv && vlast) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vlast) begin
      out_hit_r    <= fino.hit;
      out_hit_t_r  <= fino.hit ? fino.t : '0;
      out_pos_x_r  <= fino.hit ? px : '0;
      out_pos_y_r  <= fino.hit ? py : '0;
      out_pos_z_r  <= fino.hit ? pz : '0;
      out_norm_x_r <= fino.hit ? nx_nxt : '0;
      out_norm_y_r <= fino.hit ? ny_nxt : '0;
      out_norm_z_r <= fino.hit ? nz_nxt : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_hit_t  = out_hit_t_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;
  assign out_pos_z  = out_pos_z_r;
  assign out_norm_x = out_norm_x_r;
  assign out_norm_y = out_norm_y_r;
  assign out_norm_z = out_norm_z_r;

`ifndef SYNTHESIS
  // input is held back only when a result is blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a blocked output");

  // a miss carries all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_t == '0 && out_pos_x == '0 && out_pos_y == '0
      && out_pos_z == '0 && out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0))
    else $error("miss with nonzero fields");

  // a blocked last stage keeps its item
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vlast && !adv) |=> vlast)
    else $error("blocked item lost");

  // a hit has a kind and a nonnegative distance
  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (v10_r && hit10_r) |-> (kind10_r != KIND_NONE && !t10_r[63]))
    else $error("hit without kind or with negative distance");
`endif

endmodule
